// ===== design/mtep_pkg.sv =====
// Shared types, codes and decode helpers for the MIDI track event parser.
// No dependencies; imported by the step logic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

    // Parse phases of the track byte stream.
    typedef enum logic [3:0] {
        PH_DELTA     = 4'd0,
        PH_STATUS    = 4'd1,
        PH_META_TYPE = 4'd2,
        PH_META_LEN  = 4'd3,
        PH_SYSEX_LEN = 4'd4,
        PH_DATA1     = 4'd5,
        PH_DATA2     = 4'd6,
        PH_SKIP      = 4'd7,
        PH_HALT      = 4'd8
    } phase_t;

    // Event kinds reported on the output stream.
    typedef enum logic [3:0] {
        EV_NOTE_OFF      = 4'd0,
        EV_NOTE_ON       = 4'd1,
        EV_POLY_PRESSURE = 4'd2,
        EV_CONTROL       = 4'd3,
        EV_PITCH_BEND    = 4'd4,
        EV_PROGRAM       = 4'd5,
        EV_CHAN_PRESSURE = 4'd6,
        EV_TEMPO         = 4'd7,
        EV_END_OF_TRACK  = 4'd8
    } event_kind_t;

    // Status and meta codes.
    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] META_TEMPO      = 8'h51;
    localparam logic [7:0] META_END        = 8'h2F;
    localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
    localparam logic [3:0] HI_NOTE_ON      = 4'h9;
    localparam logic [3:0] HI_POLY         = 4'hA;
    localparam logic [3:0] HI_CONTROL      = 4'hB;
    localparam logic [3:0] HI_PROGRAM      = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS   = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND   = 4'hE;

    // Parser state carried from byte to byte.
    typedef struct packed {
        phase_t      phase;
        logic [31:0] tick_total;
        logic [27:0] vlq_value;
        logic [1:0]  vlq_bytes_seen;
        logic [7:0]  running_status;
        logic [7:0]  current_status;
        logic [7:0]  held_data;
        logic [7:0]  meta_type;
        logic [27:0] skip_remaining;
        logic [23:0] tempo_gather;
        logic        tempo_wanted;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:          PH_DELTA,
        tick_total:     32'd0,
        vlq_value:      28'd0,
        vlq_bytes_seen: 2'd0,
        running_status: 8'd0,
        current_status: 8'd0,
        held_data:      8'd0,
        meta_type:      8'd0,
        skip_remaining: 28'd0,
        tempo_gather:   24'd0,
        tempo_wanted:   1'b0
    };

    // One decoded event.
    typedef struct packed {
        event_kind_t kind;
        logic [31:0] tick;
        logic [3:0]  channel;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [23:0] tempo;
    } result_t;

    // Phase that follows a status byte.
    function automatic phase_t phase_for_status(input logic [7:0] s);
        phase_t ph;
        if (s == STATUS_META) begin
            ph = PH_META_TYPE;
        end else if (s == STATUS_SYSEX || s == STATUS_SYSEX_ESC) begin
            ph = PH_SYSEX_LEN;
        end else if (s[7] && s[7:4] != 4'hF) begin
            ph = PH_DATA1;
        end else begin
            ph = PH_HALT;
        end
        return ph;
    endfunction

    // Event kind of a channel message; note-on with velocity zero is note-off.
    function automatic event_kind_t channel_kind(input logic [3:0] hi,
                                                 input logic [7:0] d2);
        event_kind_t k;
        case (hi)
            HI_NOTE_OFF:   k = EV_NOTE_OFF;
            HI_NOTE_ON:    k = (d2 == 8'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
            HI_POLY:       k = EV_POLY_PRESSURE;
            HI_CONTROL:    k = EV_CONTROL;
            HI_PITCH_BEND: k = EV_PITCH_BEND;
            HI_PROGRAM:    k = EV_PROGRAM;
            default:       k = EV_CHAN_PRESSURE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== design/mtep_step.sv =====
// Combinational next-state and event decode for one track byte.
// Depends on mtep_pkg for the state, result and code definitions.
`timescale 1ns / 1ps
`default_nettype none

module mtep_step
    import mtep_pkg::*;
#(
    parameter int VLQ_MAX_BYTES = 4
) (
    input  state_t     cur,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output state_t     nxt,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [2:0] VLQ_LIMIT = 3'(VLQ_MAX_BYTES);

    always_comb
    begin
        phase_t      ph;
        logic [7:0]  cs;
        logic        go;
        logic [27:0] vv;
        logic [1:0]  vs;
        logic [2:0]  vn;
        logic        vdone;
        logic [27:0] skip_dec;
        logic [23:0] tg;

        nxt       = cur;
        res_valid = 1'b0;
        res       = '{kind: EV_NOTE_OFF, tick: cur.tick_total, channel: 4'd0,
                      first_data: 8'd0, second_data: 8'd0, tempo: 24'd0};
        ph        = cur.phase;
        cs        = cur.current_status;
        vv        = cur.vlq_value;
        vs        = cur.vlq_bytes_seen;
        go        = 1'b1;

        // Status byte, or a data byte under running status.
        if (ph == PH_STATUS) begin
            cs = data_byte[7] ? data_byte : cur.running_status;
            if (data_byte[7]) begin
                nxt.running_status = data_byte;
            end
            ph = phase_for_status(cs);
            vv = 28'd0;
            vs = 2'd0;
            go = !data_byte[7];
        end

        // Shared VLQ accumulate step, used by the phases that read a VLQ.
        vn    = {1'b0, vs} + 3'd1;
        vdone = !data_byte[7] || (vn >= VLQ_LIMIT);
        skip_dec = cur.skip_remaining - 28'd1;
        tg       = {cur.tempo_gather[15:0], data_byte};

        if (go) begin
            case (ph)
                PH_DELTA:
                begin
                    vv = {vv[20:0], data_byte[6:0]};
                    if (vdone) begin
                        nxt.tick_total = cur.tick_total + {4'd0, vv};
                        vv = 28'd0;
                        vs = 2'd0;
                        ph = PH_STATUS;
                    end else begin
                        vs = vn[1:0];
                    end
                end
                PH_META_TYPE:
                begin
                    nxt.meta_type = data_byte;
                    vv = 28'd0;
                    vs = 2'd0;
                    ph = PH_META_LEN;
                    if (last_byte && data_byte == META_END) begin
                        res_valid = 1'b1;
                        res.kind  = EV_END_OF_TRACK;
                    end
                end
                PH_META_LEN:
                begin
                    vv = {vv[20:0], data_byte[6:0]};
                    if ((vdone || last_byte) && cur.meta_type == META_END) begin
                        res_valid = 1'b1;
                        res.kind  = EV_END_OF_TRACK;
                    end
                    if (vdone) begin
                        nxt.tempo_wanted   = (cur.meta_type == META_TEMPO) &&
                                             (vv == 28'd3);
                        nxt.tempo_gather   = 24'd0;
                        nxt.skip_remaining = vv;
                        ph = (vv == 28'd0) ? PH_DELTA : PH_SKIP;
                        vv = 28'd0;
                        vs = 2'd0;
                    end else begin
                        vs = vn[1:0];
                    end
                end
                PH_SYSEX_LEN:
                begin
                    vv = {vv[20:0], data_byte[6:0]};
                    if (vdone) begin
                        nxt.tempo_wanted   = 1'b0;
                        nxt.skip_remaining = vv;
                        ph = (vv == 28'd0) ? PH_DELTA : PH_SKIP;
                        vv = 28'd0;
                        vs = 2'd0;
                    end else begin
                        vs = vn[1:0];
                    end
                end
                PH_DATA1:
                begin
                    if (cs[7:4] == HI_PROGRAM || cs[7:4] == HI_CHAN_PRESS) begin
                        res_valid      = 1'b1;
                        res.kind       = channel_kind(cs[7:4], 8'd0);
                        res.channel    = cs[3:0];
                        res.first_data = data_byte;
                        ph = PH_DELTA;
                    end else begin
                        nxt.held_data = data_byte;
                        ph = PH_DATA2;
                    end
                end
                PH_DATA2:
                begin
                    res_valid       = 1'b1;
                    res.kind        = channel_kind(cs[7:4], data_byte);
                    res.channel     = cs[3:0];
                    res.first_data  = cur.held_data;
                    res.second_data = data_byte;
                    ph = PH_DELTA;
                end
                PH_SKIP:
                begin
                    if (cur.tempo_wanted) begin
                        nxt.tempo_gather = tg;
                    end
                    nxt.skip_remaining = skip_dec;
                    if (skip_dec == 28'd0) begin
                        if (cur.tempo_wanted) begin
                            res_valid = 1'b1;
                            res.kind  = EV_TEMPO;
                            res.tempo = tg;
                        end
                        nxt.tempo_wanted = 1'b0;
                        ph = PH_DELTA;
                    end
                end
                default:
                begin
                    ph = PH_HALT;
                end
            endcase
        end

        nxt.phase          = ph;
        nxt.current_status = cs;
        nxt.vlq_value      = vv;
        nxt.vlq_bytes_seen = vs;

        // The final byte of the track returns the parser to its reset state.
        if (last_byte) begin
            nxt = STATE_RESET;
        end
    end

endmodule

`default_nettype wire

// ===== design/midi_track_event_parser.sv =====
// Top level of the MIDI track event parser: stream ports, state and output register.
// Depends on mtep_pkg and mtep_step.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes the payload of one track chunk, one byte per request on the
// slave stream, and reports channel, tempo and end-of-track events on the master
// stream with their absolute tick. Every byte is decoded in the cycle it is
// accepted and its event, if any, lands in the output register, so the block
// sustains one byte per clock; s_tready drops only while an event waits in the
// output register and m_tready is low. A byte with s_tlast set ends the track
// and returns the parser to its reset state after it has been handled.

module midi_track_event_parser
    import mtep_pkg::*;
#(
    parameter int VLQ_MAX_BYTES = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input byte stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,   // last_byte
    // Event stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // event_tick[31:0], midi_channel[35:32], first_data[43:36],
    // second_data[51:44], tempo_us_per_quarter[75:52], zero fill[79:76]
    output logic [79:0]      m_tdata,
    output logic [3:0]       m_tuser    // event_kind[3:0]
);

    state_t  state_reg;
    state_t  state_next;
    logic    out_valid_reg;
    result_t out_reg;
    logic    step_valid;
    result_t step_res;
    logic    accept;

    // Decode of the offered byte against the current state.
    mtep_step #(
        .VLQ_MAX_BYTES(VLQ_MAX_BYTES)
    ) u_step (
        .cur       (state_reg),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .nxt       (state_next),
        .res_valid (step_valid),
        .res       (step_res)
    );

    // A byte is taken whenever the output register is empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Parser state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            state_reg     <= state_next;
            out_valid_reg <= step_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (accept && step_valid) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'd0, out_reg.tempo, out_reg.second_data, out_reg.first_data,
                       out_reg.channel, out_reg.tick};

endmodule

`default_nettype wire

// ===== tb/tb_midi_track_event_parser.sv =====
// Testbench for midi_track_event_parser: directed and random track chunks go in as a
// byte stream, and every event is checked against a byte-level predictor in a scoreboard.
// Depends on mtep_pkg and the RTL of midi_track_event_parser.
`timescale 1ns / 1ps

module tb_midi_track_event_parser;
    import mtep_pkg::*;

    localparam int         VLQ_LIMIT    = 4;
    localparam int         TARGET_BYTES = 1050;
    localparam int         LIMIT_CYCLES = 400000;
    localparam logic [3:0] SYS_NIBBLE   = 4'hF;

    // Predicts the events of the byte stream and checks the ones the block reports.
    class midi_event_scoreboard;
        phase_t      phase;
        logic [31:0] tick;
        logic [27:0] vlq_acc;
        logic [1:0]  vlq_cnt;
        logic [7:0]  run_status;
        logic [7:0]  cur_status;
        logic [7:0]  held;
        logic [7:0]  meta_code;
        logic [27:0] skip_left;
        logic [23:0] tempo_acc;
        logic        tempo_on;
        result_t     pending_events[$];
        int          errors;
        int          checked;
        int          kind_count[9];

        function new();
            clear_state();
            errors = 0;
            checked = 0;
            foreach (kind_count[i])
            begin
                kind_count[i] = 0;
            end
        endfunction

        function void clear_state();
            phase = PH_DELTA;
            tick = '0;
            vlq_acc = '0;
            vlq_cnt = '0;
            run_status = '0;
            cur_status = '0;
            held = '0;
            meta_code = '0;
            skip_left = '0;
            tempo_acc = '0;
            tempo_on = 1'b0;
        endfunction

        // Shifts one byte into the quantity; true once the quantity is complete.
        function bit vlq_step(logic [7:0] b);
            int n;
            n = vlq_cnt + 1;
            vlq_acc = {vlq_acc[20:0], b[6:0]};
            if (!b[7] || n >= VLQ_LIMIT)
            begin
                return 1'b1;
            end
            vlq_cnt = n[1:0];
            return 1'b0;
        endfunction

        function event_kind_t channel_event(logic [3:0] hi, logic [7:0] d2);
            if (hi == HI_NOTE_ON) return (d2 != 8'd0) ? EV_NOTE_ON : EV_NOTE_OFF;
            if (hi == HI_NOTE_OFF) return EV_NOTE_OFF;
            if (hi == HI_POLY) return EV_POLY_PRESSURE;
            if (hi == HI_CONTROL) return EV_CONTROL;
            if (hi == HI_PROGRAM) return EV_PROGRAM;
            if (hi == HI_PITCH_BEND) return EV_PITCH_BEND;
            return EV_CHAN_PRESSURE;
        endfunction

        function void expect_event(event_kind_t k, logic [3:0] ch, logic [7:0] d1,
                                   logic [7:0] d2, logic [23:0] tempo);
            result_t r;
            r.kind = k;
            r.tick = tick;
            r.channel = ch;
            r.first_data = d1;
            r.second_data = d2;
            r.tempo = tempo;
            pending_events = {pending_events, r};
        endfunction

        // Notes one accepted request; returns whether the parser was still parsing.
        function bit take_byte(logic [7:0] b, logic l);
            bit          live;
            bit          go;
            bit          done;
            logic [7:0]  st;
            logic [27:0] len;
            logic [3:0]  hi;
            logic [3:0]  ch;
            live = (phase != PH_HALT);
            go = 1'b1;
            // A status byte, or a data byte that falls back on the running status.
            if (phase == PH_STATUS)
            begin
                st = b[7] ? b : run_status;
                if (b[7])
                begin
                    run_status = b;
                end
                cur_status = st;
                if (st == STATUS_META)
                begin
                    phase = PH_META_TYPE;
                end
                else if (st == STATUS_SYSEX || st == STATUS_SYSEX_ESC)
                begin
                    phase = PH_SYSEX_LEN;
                end
                else if (st[7] && st[7:4] != SYS_NIBBLE)
                begin
                    phase = PH_DATA1;
                end
                else
                begin
                    phase = PH_HALT;
                end
                vlq_acc = '0;
                vlq_cnt = '0;
                go = !b[7];
            end
            hi = cur_status[7:4];
            ch = cur_status[3:0];
            if (go)
            begin
                case (phase)
                    PH_DELTA:
                    begin
                        if (vlq_step(b))
                        begin
                            tick = tick + {4'd0, vlq_acc};
                            vlq_acc = '0;
                            vlq_cnt = '0;
                            phase = PH_STATUS;
                        end
                    end
                    PH_META_TYPE:
                    begin
                        meta_code = b;
                        vlq_acc = '0;
                        vlq_cnt = '0;
                        phase = PH_META_LEN;
                        if (l && meta_code == META_END)
                        begin
                            expect_event(EV_END_OF_TRACK, 4'd0, 8'd0, 8'd0, 24'd0);
                        end
                    end
                    PH_META_LEN:
                    begin
                        done = vlq_step(b);
                        if ((done || l) && meta_code == META_END)
                        begin
                            expect_event(EV_END_OF_TRACK, 4'd0, 8'd0, 8'd0, 24'd0);
                        end
                        if (done)
                        begin
                            len = vlq_acc;
                            vlq_acc = '0;
                            vlq_cnt = '0;
                            tempo_on = (meta_code == META_TEMPO && len == 28'd3);
                            tempo_acc = '0;
                            skip_left = len;
                            phase = (len == 28'd0) ? PH_DELTA : PH_SKIP;
                        end
                    end
                    PH_SYSEX_LEN:
                    begin
                        if (vlq_step(b))
                        begin
                            len = vlq_acc;
                            vlq_acc = '0;
                            vlq_cnt = '0;
                            tempo_on = 1'b0;
                            skip_left = len;
                            phase = (len == 28'd0) ? PH_DELTA : PH_SKIP;
                        end
                    end
                    PH_DATA1:
                    begin
                        if (hi == HI_PROGRAM || hi == HI_CHAN_PRESS)
                        begin
                            expect_event(channel_event(hi, 8'd0), ch, b, 8'd0, 24'd0);
                            phase = PH_DELTA;
                        end
                        else
                        begin
                            held = b;
                            phase = PH_DATA2;
                        end
                    end
                    PH_DATA2:
                    begin
                        expect_event(channel_event(hi, b), ch, held, b, 24'd0);
                        phase = PH_DELTA;
                    end
                    PH_SKIP:
                    begin
                        if (tempo_on)
                        begin
                            tempo_acc = {tempo_acc[15:0], b};
                        end
                        skip_left = skip_left - 28'd1;
                        if (skip_left == 28'd0)
                        begin
                            if (tempo_on)
                            begin
                                expect_event(EV_TEMPO, 4'd0, 8'd0, 8'd0, tempo_acc);
                            end
                            tempo_on = 1'b0;
                            phase = PH_DELTA;
                        end
                    end
                    default:
                    begin
                        phase = PH_HALT;
                    end
                endcase
            end
            if (l)
            begin
                clear_state();
            end
            return live;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // Checks one reported event against the oldest prediction.
        function void check_event(logic [3:0] kind, logic [79:0] data);
            result_t want;
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: kind %0d tick %0h", kind, data[31:0]);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            checked++;
            kind_count[want.kind]++;
            compare_field("event_kind", want.kind, kind);
            compare_field("event_tick", want.tick, data[31:0]);
            compare_field("midi_channel", want.channel, data[35:32]);
            compare_field("first_data", want.first_data, data[43:36]);
            compare_field("second_data", want.second_data, data[51:44]);
            compare_field("tempo_us_per_quarter", want.tempo, data[75:52]);
            compare_field("zero_fill", 32'd0, data[79:76]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [3:0]  m_tuser;

    midi_event_scoreboard sb = new();
    logic [7:0]           track_bytes[$];
    logic [7:0]           gen_status;
    bit                   track_dead;
    int                   sent_bytes = 0;
    int                   live_bytes = 0;
    int                   tracks_sent = 0;
    int                   cycles = 0;

    midi_track_event_parser #(
        .VLQ_MAX_BYTES(VLQ_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("midi_track_event_parser test failed");
            $finish;
        end
    end

    // Every event request that completes is checked.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_event(m_tuser, m_tdata);
        end
    end

    // Receiver: ready stretches of random length broken by stalls, mostly short.
    initial
    begin
        int run;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            repeat (run - 1) @(negedge clk);
            @(negedge clk);
            m_tready <= 1'b0;
            stall = ($urandom_range(0, 6) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
            repeat (stall - 1) @(negedge clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return 0;
        if (r < 19) return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Channel data: mostly proper 7-bit values, some with the top bit set.
    function automatic logic [7:0] rnd_data();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    task automatic put(logic [7:0] b);
        track_bytes = {track_bytes, b};
    endtask

    // Writes a quantity in exactly nbytes bytes, leading bytes carrying the more flag.
    task automatic put_vlq(logic [27:0] value, int nbytes);
        for (int k = nbytes - 1; k >= 0; k--)
        begin
            put({(k > 0), 7'(value >> (7 * k))});
        end
    endtask

    task automatic put_len(int len);
        put_vlq(28'(len), ($urandom_range(0, 5) == 0) ? 2 : 1);
    endtask

    // Delta time: usually one byte, sometimes longer, huge, or over-long.
    task automatic gen_delta(bit fast);
        int r;
        r = $urandom_range(0, 99);
        if (fast && r < 50)
        begin
            put_vlq(28'hFFFFFFF, 4);
        end
        else if (r < 55)
        begin
            put(8'($urandom_range(0, 127)));
        end
        else if (r < 80)
        begin
            put_vlq(28'($urandom_range(0, 16383)), 2);
        end
        else if (r < 90)
        begin
            put_vlq(28'($urandom()), $urandom_range(3, 4));
        end
        else if (r < 95)
        begin
            put_vlq(28'hFFFFFFF, 4);
        end
        else
        begin
            // Four bytes that all claim more follows.
            repeat (4) put(8'($urandom_range(128, 255)));
        end
    endtask

    task automatic gen_channel();
        logic [3:0] hi;
        logic [7:0] d1;
        logic [7:0] d2;
        d1 = rnd_data();
        d2 = rnd_data();
        if (gen_status[7] && gen_status[7:4] != SYS_NIBBLE && $urandom_range(0, 2) == 0)
        begin
            // Running status; the first data byte must not look like a status.
            hi = gen_status[7:4];
            d1[7] = 1'b0;
        end
        else
        begin
            hi = 4'($urandom_range(8, 14));
            gen_status = {hi, 4'($urandom_range(0, 15))};
            put(gen_status);
        end
        if (hi == HI_NOTE_ON && $urandom_range(0, 3) == 0)
        begin
            d2 = 8'd0;
        end
        put(d1);
        if (hi != HI_PROGRAM && hi != HI_CHAN_PRESS)
        begin
            put(d2);
        end
    endtask

    task automatic gen_meta();
        logic [7:0] code;
        int         len;
        int         r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            code = META_TEMPO;
        end
        else if (r == 4)
        begin
            code = META_END;
        end
        else
        begin
            code = rnd_byte();
        end
        len = (code == META_TEMPO && $urandom_range(0, 4) != 0) ? 3 : $urandom_range(0, 6);
        put(STATUS_META);
        put(code);
        put_len(len);
        repeat (len) put(rnd_byte());
        gen_status = STATUS_META;
    endtask

    task automatic gen_sysex();
        int len;
        gen_status = ($urandom_range(0, 1) == 0) ? STATUS_SYSEX : STATUS_SYSEX_ESC;
        put(gen_status);
        len = $urandom_range(0, 8);
        put_len(len);
        repeat (len) put(rnd_byte());
    endtask

    // A status the parser does not know; the rest of the track is ignored.
    task automatic gen_unknown();
        logic [7:0] st;
        if (gen_status == 8'd0 && $urandom_range(0, 1) == 0)
        begin
            put(8'($urandom_range(0, 127)));
        end
        else
        begin
            st = {SYS_NIBBLE, 4'($urandom_range(0, 15))};
            while (st == STATUS_SYSEX || st == STATUS_SYSEX_ESC || st == STATUS_META)
            begin
                st = {SYS_NIBBLE, 4'($urandom_range(0, 15))};
            end
            put(st);
        end
        repeat ($urandom_range(0, 4)) put(rnd_byte());
        track_dead = 1'b1;
    endtask

    // A whole track: mostly well formed, with a few cut short or broken.
    task automatic build_track();
        int events;
        int r;
        int keep;
        bit fast;
        gen_status = 8'd0;
        track_dead = 1'b0;
        fast = ($urandom_range(0, 6) == 0);
        events = $urandom_range(1, 8);
        repeat (events)
        begin
            if (!track_dead)
            begin
                gen_delta(fast);
                r = $urandom_range(0, 39);
                if (r < 22) gen_channel();
                else if (r < 32) gen_meta();
                else if (r < 38) gen_sysex();
                else gen_unknown();
            end
        end
        if (!track_dead)
        begin
            r = $urandom_range(0, 19);
            if (r < 17)
            begin
                gen_delta(fast);
                put(STATUS_META);
            end
            if (r < 14)
            begin
                put(META_END);
                put(8'd0);
            end
            else if (r == 14)
            begin
                // Data ends on the end-of-track type byte.
                put(META_END);
            end
            else if (r == 15)
            begin
                // Data ends inside the end-of-track length.
                put(META_END);
                put(8'h81);
            end
            else if (r == 16)
            begin
                // Declared length runs past the end of the data.
                put(rnd_byte());
                put(8'h7F);
                repeat ($urandom_range(0, 5)) put(rnd_byte());
            end
            else
            begin
                keep = $urandom_range(1, track_bytes.size());
                while (track_bytes.size() > keep)
                begin
                    void'(track_bytes.pop_back());
                end
            end
        end
    endtask

    // One byte request; waits out a random gap first unless the track is sent back to back.
    task automatic send_byte(logic [7:0] b, logic l, bit steady);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        do @(posedge clk); while (!s_tready);
        if (sb.take_byte(b, l))
        begin
            live_bytes++;
        end
        sent_bytes++;
    endtask

    task automatic send_track(bit steady);
        for (int i = 0; i < track_bytes.size(); i++)
        begin
            send_byte(track_bytes[i], (i == track_bytes.size() - 1), steady);
        end
        track_bytes.delete();
        tracks_sent++;
    endtask

    // Holds the sender off until every predicted event has come out.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_events.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Main sequence.
    initial
    begin
        bit paused;
        paused = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Program change, an over-long delta, channel data with the top bit set,
        // a tempo change and a proper end of track.
        put(8'h00);
        put({HI_PROGRAM, 4'h5});
        put(8'h7F);
        repeat (4) put(8'hFF);
        put({HI_NOTE_OFF, 4'h3});
        put(8'h80);
        put(8'hFF);
        put(8'h00);
        put(STATUS_META);
        put(META_TEMPO);
        put(8'h03);
        put(8'h07);
        put(8'hA1);
        put(8'h20);
        put(8'h00);
        put(STATUS_META);
        put(META_END);
        put(8'h00);
        send_track(1'b0);
        // Running status with no status seen yet stops the parser.
        put(8'h00);
        put(8'h45);
        put(8'h12);
        send_track(1'b0);
        drain();

        while (live_bytes < TARGET_BYTES)
        begin
            build_track();
            send_track($urandom_range(0, 4) == 0);
            if (!paused && live_bytes > TARGET_BYTES / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d tracks (%0d parsed live); %0d events checked.",
                 sent_bytes, tracks_sent, live_bytes, sb.checked);
        $display("Events by kind, note-off to end-of-track: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
                 sb.kind_count[4], sb.kind_count[5], sb.kind_count[6], sb.kind_count[7],
                 sb.kind_count[8]);
        if (sb.errors == 0)
        begin
            $display("midi_track_event_parser test passed");
        end
        else
        begin
            $display("midi_track_event_parser test failed");
        end
        $finish;
    end

endmodule
